@@ rtl/ranu_pkg.sv @@
// Shared types, constants and helpers for the revolute angle unwrap block.
// No dependencies; used by every module in rtl/.
`default_nettype none

package ranu_pkg;

  localparam int ANGLE_W = 32;
  localparam int CAND_W  = 36;
  localparam int TURN_W  = 20;
  localparam int RANU_TURN_SPAN = 3;

  // one turn, 2pi in Q15.16
  localparam logic [TURN_W-1:0] TWO_PI_Q16 = TURN_W'(411775);
  // twice a turn, divisor of the rounding step
  localparam logic [TURN_W:0] TWO_TURNS = {TWO_PI_Q16, 1'b0};
  localparam int RECIP_SHIFT = 43;
  localparam logic [23:0] TURN_RECIP =
    24'((64'd1 << RECIP_SHIFT) / 64'(TWO_TURNS));

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pos;
    logic signed [ANGLE_W-1:0] ref_ang;
    logic                      revolute;
    logic                      bounded;
    logic signed [ANGLE_W-1:0] lo;
    logic signed [ANGLE_W-1:0] hi;
  } joint_t;

  typedef struct packed {
    joint_t                   j;
    logic signed [CAND_W-1:0] cand;
    logic signed [CAND_W-1:0] best;
    logic [CAND_W-1:0]        best_dist;
    logic                     found;
  } cell_t;

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [CAND_W-1:0] v);
    logic signed [CAND_W-1:0] vmax;
    logic signed [CAND_W-1:0] vmin;
    vmax = CAND_W'(64'sh7FFF_FFFF);
    vmin = CAND_W'(-64'sh8000_0000);
    if (v > vmax) begin
      return vmax[ANGLE_W-1:0];
    end else if (v < vmin) begin
      return vmin[ANGLE_W-1:0];
    end
    return v[ANGLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ranu_front.sv @@
// Front pipeline: turn count rounding by reciprocal multiply and the first candidate.
// Depends on ranu_pkg.
`default_nettype none

module ranu_front
  import ranu_pkg::*;
#(
  parameter int TURN_SPAN = RANU_TURN_SPAN
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire joint_t in_joint,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cell_t      out_cell
);

  localparam int NST = 6;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  joint_t j1, j2, j3, j4, j5, j6;
  logic neg1, neg2, neg3;
  logic [33:0] n1, n2, n3;
  logic [47:0] p2;
  logic [14:0] q3;
  logic [34:0] m3;
  logic signed [15:0] ctr4;
  logic signed [CAND_W-1:0] prod5;
  logic signed [CAND_W-1:0] cand6;

  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [33:0] n_c;
  logic [14:0] q_est;
  logic [34:0] rem;
  logic [14:0] q_fix;
  logic signed [16:0] k0;
  logic signed [TURN_W:0] turn_s;
  logic signed [37:0] prod_full;

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    diff = {in_joint.ref_ang[ANGLE_W-1], in_joint.ref_ang}
         - {in_joint.pos[ANGLE_W-1], in_joint.pos};
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    n_c  = {mag, 1'b0} + 34'(TWO_PI_Q16);
    q_est = p2[47:33];
    rem   = {1'b0, n3} - m3;
    q_fix = q3 + 15'(rem >= 35'(TWO_TURNS));
    k0     = {ctr4[15], ctr4} - 17'(TURN_SPAN);
    turn_s = $signed({1'b0, TWO_PI_Q16});
    prod_full = k0 * turn_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      j1   <= in_joint;
      neg1 <= diff[32];
      n1   <= n_c;
    end
    if (rdy[1]) begin
      j2   <= j1;
      neg2 <= neg1;
      n2   <= n1;
      p2   <= n1[33:10] * TURN_RECIP;
    end
    if (rdy[2]) begin
      j3   <= j2;
      neg3 <= neg2;
      n3   <= n2;
      q3   <= q_est;
      m3   <= 35'(q_est) * 35'(TWO_TURNS);
    end
    if (rdy[3]) begin
      j4   <= j3;
      ctr4 <= neg3 ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    end
    if (rdy[4]) begin
      j5    <= j4;
      prod5 <= prod_full[CAND_W-1:0];
    end
    if (rdy[5]) begin
      j6    <= j5;
      cand6 <= CAND_W'(j5.pos) + prod5;
    end
  end

  assign out_valid          = v[NST-1];
  assign out_cell.j         = j6;
  assign out_cell.cand      = cand6;
  assign out_cell.best      = '0;
  assign out_cell.best_dist = '0;
  assign out_cell.found     = 1'b0;

endmodule

`default_nettype wire

@@ rtl/ranu_cell.sv @@
// One candidate cell: tests its candidate, keeps the nearest so far, passes the next turn on.
// Depends on ranu_pkg.
`default_nettype none

module ranu_cell
  import ranu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire cell_t in_cell,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cell_t      out_cell
);

  logic  v;
  cell_t c;
  cell_t c_next;
  logic  ok;
  logic  take;
  logic signed [CAND_W:0] dd;
  logic [CAND_W-1:0] dmag;

  assign in_ready = !v || out_ready;

  always_comb begin
    ok   = !in_cell.j.bounded
        || (in_cell.cand >= CAND_W'(in_cell.j.lo) && in_cell.cand <= CAND_W'(in_cell.j.hi));
    dd   = (CAND_W+1)'(in_cell.cand) - (CAND_W+1)'(in_cell.j.ref_ang);
    dmag = dd[CAND_W] ? CAND_W'(-dd) : CAND_W'(dd);
    take = ok && (!in_cell.found || dmag < in_cell.best_dist);
    c_next = in_cell;
    c_next.cand = in_cell.cand + CAND_W'(TWO_PI_Q16);
    if (take) begin
      c_next.best      = in_cell.cand;
      c_next.best_dist = dmag;
      c_next.found     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      c <= c_next;
    end
  end

  assign out_valid = v;
  assign out_cell  = c;

endmodule

`default_nettype wire

@@ rtl/revolute_angle_nearest_unwrap.sv @@
// Revolute joint unwrap: moves a joint angle by whole turns to the equivalent position nearest
// a reference, within optional limits. Takes one item per clock with no gaps unless out_ready
// holds a pending result back. Stages: six front stages (turn rounding via two multiplies and a
// correction, then the first candidate), one cell per candidate offset, and the output register.
// Depends on ranu_pkg, ranu_front, ranu_cell.
`default_nettype none

module revolute_angle_nearest_unwrap
  import ranu_pkg::*;
#(
  parameter int TURN_SPAN = RANU_TURN_SPAN
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [ANGLE_W-1:0] joint_angle,
  input  wire logic signed [ANGLE_W-1:0] reference_angle,
  input  wire logic                      is_revolute,
  input  wire logic                      has_limits,
  input  wire logic signed [ANGLE_W-1:0] lower_limit,
  input  wire logic signed [ANGLE_W-1:0] upper_limit,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [ANGLE_W-1:0]      unwrapped_angle,
  output logic                           none_in_bounds
);

  localparam int NCELL = 2 * TURN_SPAN + 1;

  joint_t jin;
  cell_t  ch [NCELL+1];
  logic   cv [NCELL+1];
  logic   cr [NCELL+1];

  logic ov;
  logic signed [ANGLE_W-1:0] res_angle;
  logic res_none;

  assign jin.pos      = joint_angle;
  assign jin.ref_ang  = reference_angle;
  assign jin.revolute = is_revolute;
  assign jin.bounded  = has_limits;
  assign jin.lo       = lower_limit;
  assign jin.hi       = upper_limit;

  ranu_front #(.TURN_SPAN(TURN_SPAN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_joint  (jin),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_cell  (ch[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ranu_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_cell   (ch[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_cell  (ch[g+1])
    );
  end

  assign cr[NCELL] = !ov || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cr[NCELL]) begin
      ov <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[NCELL]) begin
      res_none <= ch[NCELL].j.revolute && !ch[NCELL].found;
      if (ch[NCELL].j.revolute && ch[NCELL].found) begin
        res_angle <= sat32(ch[NCELL].best);
      end else begin
        res_angle <= ch[NCELL].j.pos;
      end
    end
  end

  assign out_valid       = ov;
  assign unwrapped_angle = res_angle;
  assign none_in_bounds  = res_none;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (ov && !out_ready))
    else $error("input stalled while the output stage could move");

  a_unbounded_found: assert property (@(posedge clk) disable iff (rst)
    (cv[NCELL] && ch[NCELL].j.revolute && !ch[NCELL].j.bounded) |-> ch[NCELL].found)
    else $error("unlimited revolute joint ended with no candidate");

  a_best_in_limits: assert property (@(posedge clk) disable iff (rst)
    (cv[NCELL] && ch[NCELL].j.bounded && ch[NCELL].found)
      |-> (ch[NCELL].best >= CAND_W'(ch[NCELL].j.lo) && ch[NCELL].best <= CAND_W'(ch[NCELL].j.hi)))
    else $error("chosen candidate lies outside the limits");

  a_none_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready) |=> (ov && $stable(none_in_bounds) && $stable(unwrapped_angle)))
    else $error("pending result changed while stalled");

endmodule

`default_nettype wire

@@ sim/tb_revolute_angle_nearest_unwrap.sv @@
// Self-checking testbench for revolute_angle_nearest_unwrap: directed and random joints,
// random idling on both channels, checked against an in-bench model of the turn unwrap.
// Depends on ranu_pkg and revolute_angle_nearest_unwrap from rtl/.
module tb_revolute_angle_nearest_unwrap
  import ranu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TURN_Q16 = 411775;
  localparam int SPAN = RANU_TURN_SPAN;
  localparam int PIPE_DEPTH = 2 * SPAN + 8;
  localparam int RANDOM_JOINTS = 1300;
  localparam int HOLD_LONG = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint ANGLE_MAX = 64'sd2147483647;
  localparam longint ANGLE_MIN = -64'sd2147483648;
  localparam logic signed [31:0] A_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] A_MIN = 32'sh8000_0000;
  localparam int T = 411775;

  typedef struct {
    joint_t      j;
    int unsigned gap;
    bit          drain_first;
  } offer_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic                      flag;
  } unwrap_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  joint_t drv = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] unwrapped_angle;
  logic   none_in_bounds;

  offer_t  joint_queue[$];
  unwrap_t unwrap_due[$];
  offer_t  head;
  unwrap_t due;
  int unsigned gap_count;
  int unsigned hold_draw;
  int joints_taken = 0;
  int joints_planned = 0;
  int results_seen = 0;
  int hold_cycles;
  int fails = 0;
  int quiet_cycles;

  revolute_angle_nearest_unwrap u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .joint_angle     (drv.pos),
    .reference_angle (drv.ref_ang),
    .is_revolute     (drv.revolute),
    .has_limits      (drv.bounded),
    .lower_limit     (drv.lo),
    .upper_limit     (drv.hi),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .unwrapped_angle (unwrapped_angle),
    .none_in_bounds  (none_in_bounds)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic unwrap_t predict_unwrap(joint_t j);
    longint pos, target, lo, hi, diff, mag, center, cand, delta, best, best_dist;
    bit found;
    int k;
    unwrap_t r;
    pos = j.pos;
    target = j.ref_ang;
    lo = j.lo;
    hi = j.hi;
    best = pos;
    best_dist = 0;
    found = 1'b0;
    r.flag = 1'b0;
    r.angle = j.pos;
    if (!j.revolute) begin
      return r;
    end
    diff = target - pos;
    mag = (diff < 0) ? -diff : diff;
    center = (2 * mag + TURN_Q16) / (2 * TURN_Q16);
    if (diff < 0) begin
      center = -center;
    end
    for (k = -SPAN; k <= SPAN; k++) begin
      cand = pos + (center + k) * TURN_Q16;
      delta = cand - target;
      if (delta < 0) begin
        delta = -delta;
      end
      if ((!j.bounded || (cand >= lo && cand <= hi)) && (!found || delta < best_dist)) begin
        best = cand;
        best_dist = delta;
        found = 1'b1;
      end
    end
    r.flag = !found;
    if (best > ANGLE_MAX) begin
      r.angle = A_MAX;
    end else if (best < ANGLE_MIN) begin
      r.angle = A_MIN;
    end else begin
      r.angle = 32'(best);
    end
    return r;
  endfunction

  function automatic joint_t make_joint(logic signed [31:0] p, logic signed [31:0] r,
                                        logic rev, logic bnd,
                                        logic signed [31:0] l, logic signed [31:0] h);
    joint_t j;
    j.pos = p;
    j.ref_ang = r;
    j.revolute = rev;
    j.bounded = bnd;
    j.lo = l;
    j.hi = h;
    return j;
  endfunction

  // mostly well-formed joints near their reference, with fully random noise mixed in
  function automatic joint_t random_joint();
    joint_t j;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    j.pos = $urandom;
    j.ref_ang = $urandom;
    j.lo = $urandom;
    j.hi = $urandom;
    j.revolute = 1'b1;
    j.bounded = 1'b0;
    if (kind == 0) begin
      j.revolute = 1'b0;
      j.bounded = 1'($urandom_range(0, 1));
    end else if (kind == 1) begin
      j.revolute = 1'($urandom_range(0, 1));
      j.bounded = 1'($urandom_range(0, 1));
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        j.pos = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      end
      j.ref_ang = j.pos + (int'($urandom_range(0, 16 * T)) - 8 * T);
      if (kind >= 5 && kind <= 8) begin
        j.bounded = 1'b1;
        j.lo = j.ref_ang - int'($urandom_range(0, 900000));
        j.hi = j.ref_ang + int'($urandom_range(0, 900000));
      end else if (kind == 9) begin
        j.bounded = 1'b1;
        j.lo = j.ref_ang + int'($urandom_range(0, 8 * T)) - 4 * T;
        j.hi = j.lo + int'($urandom_range(0, 500000)) - 50000;
      end
    end
    return j;
  endfunction

  task automatic queue_joint(joint_t j, bit idle, bit drain);
    offer_t o;
    o.j = j;
    o.drain_first = drain;
    o.gap = (idle && $urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : 0;
    joint_queue.insert(joint_queue.size(), o);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        unwrap_due.insert(unwrap_due.size(), predict_unwrap(drv));
        joints_taken++;
      end
      if (!in_valid || in_ready) begin
        if (joint_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (joint_queue[0].drain_first && unwrap_due.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_count < joint_queue[0].gap) begin
          gap_count <= gap_count + 1;
          in_valid <= 1'b0;
        end else begin
          head = joint_queue.pop_front();
          drv <= head.j;
          in_valid <= 1'b1;
          gap_count <= 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (unwrap_due.size() == 0) begin
        $error("unexpected item: unwrapped_angle %0d none_in_bounds %0b",
               unwrapped_angle, none_in_bounds);
        fails++;
      end else begin
        due = unwrap_due.pop_front();
        if (unwrapped_angle !== due.angle) begin
          $error("unwrapped_angle: expected %0d, got %0d", due.angle, unwrapped_angle);
          fails++;
        end
        if (none_in_bounds !== due.flag) begin
          $error("none_in_bounds: expected %0b, got %0b", due.flag, none_in_bounds);
          fails++;
        end
      end
      if (results_seen == 200 || results_seen == 1000) begin
        hold_cycles <= HOLD_LONG;
        out_ready <= 1'b0;
      end else if (results_seen >= 470 && results_seen < 770) begin
        hold_cycles <= 0;
        out_ready <= 1'b1;
      end else begin
        hold_draw = $urandom_range(0, 17);
        hold_cycles <= hold_draw;
        out_ready <= (hold_draw == 0);
      end
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    bit idle;
    // prismatic: passes through, limits ignored even when inverted
    queue_joint(make_joint(A_MAX, A_MIN, 1'b0, 1'b1, A_MAX, A_MIN), 1'b1, 1'b0);
    queue_joint(make_joint(A_MIN, A_MAX, 1'b0, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(-12345, 7, 1'b0, 1'b1, 10, -10), 1'b1, 1'b0);
    // unlimited, including saturation at both ends and rounding near half a turn
    queue_joint(make_joint(0, 0, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(A_MIN, A_MAX, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(A_MAX, A_MIN, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(0, 205887, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(0, 205888, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(0, -205888, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(0, -205887, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(100000, 100000 + 3 * T + 7, 1'b1, 1'b0, 0, 0), 1'b1, 1'b0);
    queue_joint(make_joint(-1, A_MAX, 1'b1, 1'b0, A_MAX, A_MIN), 1'b1, 1'b0);
    // limited: wide, inverted, single point, off-center windows, none reachable
    queue_joint(make_joint(1000, -2000000, 1'b1, 1'b1, A_MIN, A_MAX), 1'b1, 1'b0);
    queue_joint(make_joint(A_MAX, A_MIN, 1'b1, 1'b1, A_MIN, A_MAX), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, 10, -10), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, T, T), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, -T, -T), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, 300000, 500000), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, 100, 200), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, 3 * T, 3 * T + 10), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, -3 * T - 10, -3 * T), 1'b1, 1'b0);
    queue_joint(make_joint(0, 0, 1'b1, 1'b1, 4 * T, 5 * T), 1'b1, 1'b0);
    queue_joint(make_joint(A_MAX - 5, A_MAX, 1'b1, 1'b1, A_MAX - 10, A_MAX), 1'b1, 1'b0);
    queue_joint(make_joint(A_MIN, A_MIN, 1'b1, 1'b1, A_MIN, A_MIN), 1'b1, 1'b0);

    for (n = 0; n < RANDOM_JOINTS; n++) begin
      idle = !(n >= 450 && n < 750);
      queue_joint(random_joint(), idle,
                  n == 0 || n == 450 || n == 750 || (n % 300) == 299);
    end
    joints_planned = joint_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (joints_taken != joints_planned || unwrap_due.size() != 0);
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    if (fails == 0 && unwrap_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ranu_pkg.sv
rtl/ranu_front.sv
rtl/ranu_cell.sv
rtl/revolute_angle_nearest_unwrap.sv
sim/tb_revolute_angle_nearest_unwrap.sv
